// ===== design/mbx_pkg.sv =====
// Shared types and constants of the broadcast mailbox.
// Depends on nothing; used by the slot store, the match unit and the top level.
`timescale 1ns / 1ps

package mbx_pkg;

   // Default sizing of the mailbox
   localparam int SLOT_COUNT_DEF    = 8;
   localparam int PAYLOAD_BYTES_DEF = 16;
   localparam int CORE_COUNT_DEF    = 4;

   // Fixed field widths of the request and response beats
   localparam int CPU_ID_W  = 2;
   localparam int DST_W     = 4;
   localparam int WORD_W    = 32;
   localparam int COUNT_W   = 5;
   localparam int WORD_NUM  = 4;
   localparam int MAX_BYTES = 16;

   // Request codes
   typedef enum logic {
      REQ_SEND = 1'b0,
      REQ_GET  = 1'b1
   } mbx_req_type;

   // Write strobes from the sequencer into the slot store
   typedef struct packed {
      logic mask_we;
      logic data_we;
   } mbx_wr_ctl_type;

endpackage

// ===== design/mbx_store.sv =====
// Slot store of the mailbox: mask, id and payload memories plus per-slot valid bits.
// Depends on mbx_pkg.
`timescale 1ns / 1ps

module mbx_store #(
   parameter int SLOT_COUNT    = 8,
   parameter int PAYLOAD_BYTES = 16,
   parameter int CORE_COUNT    = 4,
   parameter int IDX_W         = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [IDX_W-1:0]              mask_rd_addr,
   output logic [CORE_COUNT-1:0]         mask_rd_dest,
   output logic [CORE_COUNT-1:0]         mask_rd_read,
   input  logic [IDX_W-1:0]              data_rd_addr,
   output logic [mbx_pkg::WORD_W-1:0]    id_rd,
   output logic [PAYLOAD_BYTES*8-1:0]    pay_rd,
   input  mbx_pkg::mbx_wr_ctl_type       wr_ctl,
   input  logic [IDX_W-1:0]              wr_addr,
   input  logic [CORE_COUNT-1:0]         wr_dest,
   input  logic [CORE_COUNT-1:0]         wr_read,
   input  logic [mbx_pkg::WORD_W-1:0]    wr_id,
   input  logic [PAYLOAD_BYTES*8-1:0]    wr_pay,
   input  logic [PAYLOAD_BYTES-1:0]      wr_be
);
   import mbx_pkg::*;

   logic [2*CORE_COUNT-1:0]         mask_mem [SLOT_COUNT];
   logic [WORD_W-1:0]               id_mem   [SLOT_COUNT];
   logic [PAYLOAD_BYTES-1:0][7:0]   pay_mem  [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]           vld_ff;
   logic                            rd_vld_ff;
   logic [2*CORE_COUNT-1:0]         mask_rd_ff;
   logic [WORD_W-1:0]               id_rd_ff;
   logic [PAYLOAD_BYTES-1:0][7:0]   pay_rd_ff;

   // Mark slots written since reset; an unmarked slot's mask reads as all zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= vld_ff[mask_rd_addr];
         if (wr_ctl.data_we) begin
            vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Mask memory: one read port for the scan, one write port
   always_ff @(posedge clock) begin
      mask_rd_ff <= mask_mem[mask_rd_addr];
      if (wr_ctl.mask_we) begin
         mask_mem[wr_addr] <= {wr_dest, wr_read};
      end
   end

   // Id and payload memories; fill untouched bytes with zero on a slot's first write
   always_ff @(posedge clock) begin
      id_rd_ff  <= id_mem[data_rd_addr];
      pay_rd_ff <= pay_mem[data_rd_addr];
      if (wr_ctl.data_we) begin
         id_mem[wr_addr] <= wr_id;
         for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            if (wr_be[k]) begin
               pay_mem[wr_addr][k] <= wr_pay[8*k +: 8];
            end else if (!vld_ff[wr_addr]) begin
               pay_mem[wr_addr][k] <= 8'h00;
            end
         end
      end
   end

   assign mask_rd_dest = rd_vld_ff ? mask_rd_ff[2*CORE_COUNT-1:CORE_COUNT] : '0;
   assign mask_rd_read = rd_vld_ff ? mask_rd_ff[CORE_COUNT-1:0] : '0;
   assign id_rd        = id_rd_ff;
   assign pay_rd       = pay_rd_ff;

endmodule

// ===== design/mbx_match.sv =====
// Slot match unit shared by every step of the scan: free slot for a send,
// pending message for a get. Depends on mbx_pkg.
`timescale 1ns / 1ps

module mbx_match #(
   parameter int CORE_COUNT = 4
) (
   input  mbx_pkg::mbx_req_type     req_kind,
   input  logic [CORE_COUNT-1:0]    self_bit,
   input  logic [CORE_COUNT-1:0]    dest,
   input  logic [CORE_COUNT-1:0]    read,
   output logic                     hit
);
   import mbx_pkg::*;

   // Send: every addressed core has read it. Get: addressed to us, not yet read.
   always_comb begin
      case (req_kind)
         REQ_SEND: hit = (read == dest);
         REQ_GET:  hit = ((dest & self_bit) != '0) && ((read & self_bit) == '0);
         default:  hit = 1'b0;
      endcase
   end

endmodule

// ===== design/multicore_broadcast_mailbox_unit.sv =====
// Top level of the broadcast mailbox: request sequencer and response register.
// Depends on mbx_pkg, mbx_store and mbx_match.
//
//   channel  | ports                                  | direction | handshake
//   request  | req_* fields                           | in        | start & !busy
//   response | rsp_* fields                           | out       | rsp_strobe, one cycle
//
// A request scans the slots in order, one slot per cycle through the shared match
// unit, behind the registered memory read. A send that hits goes on through S_WRITE,
// a get through S_FETCH and S_DELIVER, and a miss ends at the last slot; the
// response strobe rises in the cycle busy falls (at once for an unknown core).
// Reset clears the slot valid bits, so no clearing pass is needed.
// The receiver has no stall: each response is shown for exactly one cycle.
`timescale 1ns / 1ps

module multicore_broadcast_mailbox_unit #(
   parameter int SLOT_COUNT    = mbx_pkg::SLOT_COUNT_DEF,
   parameter int PAYLOAD_BYTES = mbx_pkg::PAYLOAD_BYTES_DEF,
   parameter int CORE_COUNT    = mbx_pkg::CORE_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_type,
   input  logic [mbx_pkg::CPU_ID_W-1:0]     req_cpu_id,
   input  logic [mbx_pkg::DST_W-1:0]        req_dst_mask,
   input  logic [mbx_pkg::WORD_W-1:0]       req_msg_id,
   input  logic [mbx_pkg::COUNT_W-1:0]      req_byte_count,
   input  logic [mbx_pkg::WORD_W-1:0]       req_data_word_0,
   input  logic [mbx_pkg::WORD_W-1:0]       req_data_word_1,
   input  logic [mbx_pkg::WORD_W-1:0]       req_data_word_2,
   input  logic [mbx_pkg::WORD_W-1:0]       req_data_word_3,
   output logic                             rsp_strobe,
   output logic                             rsp_ok,
   output logic                             rsp_raise_irq,
   output logic [mbx_pkg::WORD_W-1:0]       rsp_found_msg_id,
   output logic [mbx_pkg::WORD_W-1:0]       rsp_out_word_0,
   output logic [mbx_pkg::WORD_W-1:0]       rsp_out_word_1,
   output logic [mbx_pkg::WORD_W-1:0]       rsp_out_word_2,
   output logic [mbx_pkg::WORD_W-1:0]       rsp_out_word_3
);
   import mbx_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
   localparam int PAY_W = PAYLOAD_BYTES * 8;
   localparam int ALL_W = WORD_NUM * WORD_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_WRITE,
      S_FETCH,
      S_DELIVER
   } state_type;

   state_type                 state_ff;
   mbx_req_type               kind_ff;
   logic [CORE_COUNT-1:0]     self_ff;
   logic [CORE_COUNT-1:0]     dest_new_ff;
   logic [WORD_W-1:0]         id_ff;
   logic [COUNT_W-1:0]        count_ff;
   logic [ALL_W-1:0]          data_ff;
   logic [IDX_W-1:0]          scan_addr_ff;
   logic [IDX_W-1:0]          rd_idx_ff;
   logic                      pend_ff;
   logic [IDX_W-1:0]          hit_idx_ff;
   logic [CORE_COUNT-1:0]     hit_dest_ff;
   logic [CORE_COUNT-1:0]     hit_read_ff;

   logic                      rsp_strobe_ff;
   logic                      rsp_ok_ff;
   logic                      rsp_irq_ff;
   logic [WORD_W-1:0]         rsp_id_ff;
   logic [ALL_W-1:0]          rsp_pay_ff;

   logic                      accept;
   logic                      cpu_bad;
   logic [COUNT_W-1:0]        count_in;
   logic [CORE_COUNT-1:0]     self_in;
   logic [CORE_COUNT-1:0]     dest_in;
   logic [7:0]                dst_wide;
   logic [CORE_COUNT-1:0]     mask_rd_dest;
   logic [CORE_COUNT-1:0]     mask_rd_read;
   logic [WORD_W-1:0]         id_rd;
   logic [PAY_W-1:0]          pay_rd;
   logic                      hit;
   mbx_wr_ctl_type            wr_ctl;
   logic [CORE_COUNT-1:0]     wr_dest;
   logic [CORE_COUNT-1:0]     wr_read;
   logic [PAY_W-1:0]          wr_pay;
   logic [PAYLOAD_BYTES-1:0]  wr_be;
   logic [ALL_W-1:0]          get_pay;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Decode the incoming beat: core check, clamped count, own bit, destinations
   always_comb begin
      cpu_bad  = (int'(req_cpu_id) >= CORE_COUNT);
      count_in = (int'(req_byte_count) > PAYLOAD_BYTES) ? COUNT_W'(PAYLOAD_BYTES)
                                                        : req_byte_count;
      self_in  = CORE_COUNT'(1) << req_cpu_id;
      dst_wide = {4'b0000, req_dst_mask};
      for (int i = 0; i < CORE_COUNT; i++) begin
         dest_in[i] = dst_wide[i] & ~self_in[i];
      end
   end

   mbx_store #(
      .SLOT_COUNT    (SLOT_COUNT),
      .PAYLOAD_BYTES (PAYLOAD_BYTES),
      .CORE_COUNT    (CORE_COUNT),
      .IDX_W         (IDX_W)
   ) u_store (
      .clock        (clock),
      .reset        (reset),
      .mask_rd_addr (scan_addr_ff),
      .mask_rd_dest (mask_rd_dest),
      .mask_rd_read (mask_rd_read),
      .data_rd_addr (hit_idx_ff),
      .id_rd        (id_rd),
      .pay_rd       (pay_rd),
      .wr_ctl       (wr_ctl),
      .wr_addr      (hit_idx_ff),
      .wr_dest      (wr_dest),
      .wr_read      (wr_read),
      .wr_id        (id_ff),
      .wr_pay       (wr_pay),
      .wr_be        (wr_be)
   );

   mbx_match #(
      .CORE_COUNT (CORE_COUNT)
   ) u_match (
      .req_kind (kind_ff),
      .self_bit (self_ff),
      .dest     (mask_rd_dest),
      .read     (mask_rd_read),
      .hit      (hit)
   );

   // Drive the store write port: slot fill on a send, read-bit update on a get
   always_comb begin
      wr_ctl.mask_we = (state_ff == S_WRITE) || (state_ff == S_FETCH);
      wr_ctl.data_we = (state_ff == S_WRITE);
      wr_dest        = (state_ff == S_WRITE) ? dest_new_ff : hit_dest_ff;
      wr_read        = (state_ff == S_WRITE) ? '0 : (hit_read_ff | self_ff);
      for (int k = 0; k < PAYLOAD_BYTES; k++) begin
         wr_pay[8*k +: 8] = data_ff[8*k +: 8];
         wr_be[k]         = (k < int'(count_ff));
      end
   end

   // Zero the fetched payload past the requested count
   always_comb begin
      get_pay = '0;
      for (int k = 0; k < PAYLOAD_BYTES; k++) begin
         if (k < int'(count_ff)) begin
            get_pay[8*k +: 8] = pay_rd[8*k +: 8];
         end
      end
   end

   // Sequencer: scan, then write back or fetch, and register the response beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  kind_ff      <= mbx_req_type'(req_type);
                  self_ff      <= self_in;
                  dest_new_ff  <= dest_in;
                  id_ff        <= req_msg_id;
                  count_ff     <= count_in;
                  data_ff      <= {req_data_word_3, req_data_word_2,
                                   req_data_word_1, req_data_word_0};
                  scan_addr_ff <= '0;
                  pend_ff      <= 1'b0;
                  if (cpu_bad) begin
                     // Reject the beat straight away
                     rsp_strobe_ff <= 1'b1;
                     rsp_ok_ff     <= 1'b0;
                     rsp_irq_ff    <= 1'b0;
                     rsp_id_ff     <= '0;
                     rsp_pay_ff    <= '0;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               // Advance the read address; the compare follows it in the next cycle
               rd_idx_ff <= scan_addr_ff;
               pend_ff   <= 1'b1;
               if (scan_addr_ff != LAST_IDX) begin
                  scan_addr_ff <= scan_addr_ff + IDX_W'(1);
               end
               if (pend_ff && hit) begin
                  hit_idx_ff  <= rd_idx_ff;
                  hit_dest_ff <= mask_rd_dest;
                  hit_read_ff <= mask_rd_read;
                  pend_ff     <= 1'b0;
                  state_ff    <= (kind_ff == REQ_SEND) ? S_WRITE : S_FETCH;
               end else if (pend_ff && (rd_idx_ff == LAST_IDX)) begin
                  pend_ff       <= 1'b0;
                  state_ff      <= S_IDLE;
                  rsp_strobe_ff <= 1'b1;
                  rsp_ok_ff     <= 1'b0;
                  rsp_irq_ff    <= 1'b0;
                  rsp_id_ff     <= '0;
                  rsp_pay_ff    <= '0;
               end
            end
            S_WRITE: begin
               state_ff      <= S_IDLE;
               rsp_strobe_ff <= 1'b1;
               rsp_ok_ff     <= 1'b1;
               rsp_irq_ff    <= 1'b1;
               rsp_id_ff     <= '0;
               rsp_pay_ff    <= '0;
            end
            S_FETCH: begin
               state_ff <= S_DELIVER;
            end
            S_DELIVER: begin
               state_ff      <= S_IDLE;
               rsp_strobe_ff <= 1'b1;
               rsp_ok_ff     <= 1'b1;
               rsp_irq_ff    <= 1'b0;
               rsp_id_ff     <= id_rd;
               rsp_pay_ff    <= get_pay;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_raise_irq    = rsp_irq_ff;
   assign rsp_found_msg_id = rsp_id_ff;
   assign rsp_out_word_0   = rsp_pay_ff[0*WORD_W +: WORD_W];
   assign rsp_out_word_1   = rsp_pay_ff[1*WORD_W +: WORD_W];
   assign rsp_out_word_2   = rsp_pay_ff[2*WORD_W +: WORD_W];
   assign rsp_out_word_3   = rsp_pay_ff[3*WORD_W +: WORD_W];

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the broadcast mailbox: directed and random send/get beats.
// Depends on mbx_pkg and multicore_broadcast_mailbox_unit; a local mailbox copy predicts replies.
`timescale 1ns / 1ps

module tb_top;
   import mbx_pkg::*;

   localparam int SLOTS      = SLOT_COUNT_DEF;
   localparam int PAY_BYTES  = PAYLOAD_BYTES_DEF;
   localparam int CORES      = CORE_COUNT_DEF;
   localparam logic [DST_W-1:0] CORE_MASK = DST_W'((1 << CORES) - 1);
   // Covers the longest busy stretch, a get that hits the last slot, and the reply
   localparam int SETTLE_CYCLES = SLOTS + 6;
   localparam int DRAIN_LIMIT   = 2000;
   localparam int PHASE_ITEMS   = 234;

   typedef struct packed {
      mbx_req_type               kind;
      logic [CPU_ID_W-1:0]       cpu;
      logic [DST_W-1:0]          dst;
      logic [WORD_W-1:0]         id;
      logic [COUNT_W-1:0]        count;
      logic [MAX_BYTES*8-1:0]    data;
   } mbx_request_type;

   typedef struct packed {
      logic                      ok;
      logic                      irq;
      logic [WORD_W-1:0]         id;
      logic [MAX_BYTES*8-1:0]    data;
   } mbx_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic                 req_type        = REQ_SEND;
   logic [CPU_ID_W-1:0]  req_cpu_id      = '0;
   logic [DST_W-1:0]     req_dst_mask    = '0;
   logic [WORD_W-1:0]    req_msg_id      = '0;
   logic [COUNT_W-1:0]   req_byte_count  = '0;
   logic [WORD_W-1:0]    req_data_word_0 = '0;
   logic [WORD_W-1:0]    req_data_word_1 = '0;
   logic [WORD_W-1:0]    req_data_word_2 = '0;
   logic [WORD_W-1:0]    req_data_word_3 = '0;
   logic                 rsp_strobe;
   logic                 rsp_ok;
   logic                 rsp_raise_irq;
   logic [WORD_W-1:0]    rsp_found_msg_id;
   logic [WORD_W-1:0]    rsp_out_word_0;
   logic [WORD_W-1:0]    rsp_out_word_1;
   logic [WORD_W-1:0]    rsp_out_word_2;
   logic [WORD_W-1:0]    rsp_out_word_3;

   // Local copy of the mailbox slots
   logic [DST_W-1:0]        box_dest [SLOTS];
   logic [DST_W-1:0]        box_read [SLOTS];
   logic [WORD_W-1:0]       box_id   [SLOTS];
   logic [MAX_BYTES*8-1:0]  box_data [SLOTS];

   mbx_reply_type reply_q[$];
   int mismatch_count = 0;
   int sender_idle_pct = 0;

   multicore_broadcast_mailbox_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_cpu_id       (req_cpu_id),
      .req_dst_mask     (req_dst_mask),
      .req_msg_id       (req_msg_id),
      .req_byte_count   (req_byte_count),
      .req_data_word_0  (req_data_word_0),
      .req_data_word_1  (req_data_word_1),
      .req_data_word_2  (req_data_word_2),
      .req_data_word_3  (req_data_word_3),
      .rsp_strobe       (rsp_strobe),
      .rsp_ok           (rsp_ok),
      .rsp_raise_irq    (rsp_raise_irq),
      .rsp_found_msg_id (rsp_found_msg_id),
      .rsp_out_word_0   (rsp_out_word_0),
      .rsp_out_word_1   (rsp_out_word_1),
      .rsp_out_word_2   (rsp_out_word_2),
      .rsp_out_word_3   (rsp_out_word_3)
   );

   always #4 clock = ~clock;

   initial begin
      for (int s = 0; s < SLOTS; s++) begin
         box_dest[s] = '0;
         box_read[s] = '0;
         box_id[s]   = '0;
         box_data[s] = '0;
      end
   end

   // Work out the reply of one accepted beat and advance the slot copy
   function automatic mbx_reply_type mailbox_reply(input mbx_request_type rq);
      mbx_reply_type rp;
      int slot;
      int n;
      logic [DST_W-1:0] self_bit;
      rp = '0;
      n = (rq.count > PAY_BYTES) ? PAY_BYTES : int'(rq.count);
      slot = -1;
      if (int'(rq.cpu) >= CORES) return rp;
      self_bit = DST_W'(1) << rq.cpu;
      if (rq.kind == REQ_SEND) begin
         for (int s = SLOTS - 1; s >= 0; s--)
            if (box_read[s] == box_dest[s]) slot = s;
         if (slot < 0) return rp;
         box_dest[slot] = rq.dst & CORE_MASK & ~self_bit;
         box_read[slot] = '0;
         box_id[slot]   = rq.id;
         for (int k = 0; k < n; k++) box_data[slot][8*k +: 8] = rq.data[8*k +: 8];
         rp.ok  = 1'b1;
         rp.irq = 1'b1;
      end else begin
         for (int s = SLOTS - 1; s >= 0; s--)
            if ((box_read[s] & self_bit) == '0 && (box_dest[s] & self_bit) != '0) slot = s;
         if (slot < 0) return rp;
         rp.ok = 1'b1;
         rp.id = box_id[slot];
         for (int k = 0; k < n; k++) rp.data[8*k +: 8] = box_data[slot][8*k +: 8];
         box_read[slot] = box_read[slot] | self_bit;
      end
      return rp;
   endfunction

   function automatic mbx_request_type make_req(input mbx_req_type kind, input int cpu,
                                                input int dst, input logic [WORD_W-1:0] id,
                                                input int count,
                                                input logic [MAX_BYTES*8-1:0] data);
      mbx_request_type rq;
      rq.kind  = kind;
      rq.cpu   = CPU_ID_W'(cpu);
      rq.dst   = DST_W'(dst);
      rq.id    = id;
      rq.count = COUNT_W'(count);
      rq.data  = data;
      return rq;
   endfunction

   function automatic logic [MAX_BYTES*8-1:0] random_payload();
      return {$urandom(), $urandom(), $urandom(), $urandom()};
   endfunction

   // Drive one beat at the falling edge, hold it until accepted, then predict
   task automatic post_request(input mbx_request_type rq);
      int gap;
      gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 5) : 0;
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_type        <= rq.kind;
      req_cpu_id      <= rq.cpu;
      req_dst_mask    <= rq.dst;
      req_msg_id      <= rq.id;
      req_byte_count  <= rq.count;
      req_data_word_0 <= rq.data[0*WORD_W +: WORD_W];
      req_data_word_1 <= rq.data[1*WORD_W +: WORD_W];
      req_data_word_2 <= rq.data[2*WORD_W +: WORD_W];
      req_data_word_3 <= rq.data[3*WORD_W +: WORD_W];
      start           <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      reply_q.push_back(mailbox_reply(rq));
   endtask

   // Compare each reply beat with the oldest prediction
   always @(posedge clock) begin
      mbx_reply_type want;
      mbx_reply_type got;
      if (!reset && rsp_strobe === 1'b1) begin
         got = {rsp_ok, rsp_raise_irq, rsp_found_msg_id,
                rsp_out_word_3, rsp_out_word_2, rsp_out_word_1, rsp_out_word_0};
         if (reply_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected reply: ok=%b irq=%b id=%h data=%h",
                        got.ok, got.irq, got.id, got.data);
         end else begin
            want = reply_q.pop_front();
            if (got.ok !== want.ok || got.irq !== want.irq || got.id !== want.id ||
                got.data !== want.data) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("reply mismatch: want ok=%b irq=%b id=%h data=%h",
                           want.ok, want.irq, want.id, want.data,
                           " / got ok=%b irq=%b id=%h data=%h",
                           got.ok, got.irq, got.id, got.data);
            end
         end
      end
   end

   // Full-size send, its read, then a get with nothing left
   task automatic test_send_get();
      post_request(make_req(REQ_SEND, 0, 4'b0010, '1, 16, '1));
      post_request(make_req(REQ_GET, 1, 0, '0, 16, '0));
      post_request(make_req(REQ_GET, 1, 0, '0, 16, '0));
   endtask

   // Short write into a reused slot keeps old bytes; zero-count read still returns the id
   task automatic test_partial_count();
      post_request(make_req(REQ_SEND, 3, 4'b0110, '0, 3, '0));
      post_request(make_req(REQ_GET, 2, 0, '0, 16, '0));
      post_request(make_req(REQ_GET, 1, 0, '0, 0, '0));
   endtask

   // Counts above the payload size saturate on both send and get
   task automatic test_long_count();
      post_request(make_req(REQ_SEND, 2, 4'b1001, 32'hA5A5_5A5A, 31, random_payload()));
      post_request(make_req(REQ_GET, 0, 0, '0, 17, '0));
      post_request(make_req(REQ_GET, 3, 0, '0, 31, '0));
   endtask

   // Sender's own bit is dropped; a send that addresses nobody frees its slot at once
   task automatic test_self_and_empty();
      post_request(make_req(REQ_SEND, 3, 4'b1111, 32'h1234_5678, 8, random_payload()));
      post_request(make_req(REQ_GET, 3, 0, '0, 16, '0));
      post_request(make_req(REQ_SEND, 1, 4'b0010, 32'h0F0F_F0F0, 16, random_payload()));
      post_request(make_req(REQ_GET, 0, 0, '0, 5, '0));
      post_request(make_req(REQ_GET, 1, 0, '0, 12, '0));
      post_request(make_req(REQ_GET, 2, 0, '0, 16, '0));
   endtask

   // Fill every slot, see the next send fail, free one slot and send again
   task automatic test_mailbox_full();
      for (int s = 0; s < SLOTS; s++)
         post_request(make_req(REQ_SEND, 0, 4'b0100, $urandom(), 16, random_payload()));
      post_request(make_req(REQ_SEND, 1, 4'b1000, $urandom(), 16, random_payload()));
      post_request(make_req(REQ_GET, 2, 0, '0, 16, '0));
      post_request(make_req(REQ_SEND, 1, 4'b1000, $urandom(), 9, random_payload()));
   endtask

   // Random traffic; the send share shifts per block so the mailbox fills and drains
   task automatic test_random_traffic(input int items);
      int send_pct;
      int count;
      mbx_request_type rq;
      send_pct = 50;
      for (int i = 0; i < items; i++) begin
         if (i % 25 == 0) send_pct = 25 * $urandom_range(1, 3);
         case ($urandom_range(0, 19))
            0, 1, 2:  count = 16;
            3, 4, 5:  count = $urandom_range(17, 31);
            default:  count = $urandom_range(0, 16);
         endcase
         rq = make_req(($urandom_range(0, 99) < send_pct) ? REQ_SEND : REQ_GET,
                       $urandom_range(0, 3), $urandom_range(0, 15), $urandom(), count,
                       random_payload());
         post_request(rq);
      end
   endtask

   // Hard stop
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int waited;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      sender_idle_pct = 27;
      test_send_get();
      test_partial_count();
      test_long_count();
      test_self_and_empty();
      test_mailbox_full();
      test_random_traffic(PHASE_ITEMS);
      sender_idle_pct = 45;
      test_random_traffic(PHASE_ITEMS);
      sender_idle_pct = 0;
      test_random_traffic(PHASE_ITEMS);

      @(negedge clock);
      start <= 1'b0;

      // Drain outstanding replies, then let the block settle
      waited = 0;
      while (reply_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      mismatch_count += reply_q.size();

      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
